### rtl/core/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants of the voxel ray traversal core: result codes,
// the command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package vrt_pkg;

	localparam logic [31:0] SATMAX     = 32'hFFFF_FFFF;
	localparam logic [1:0]  AXIS_X     = 2'd0;
	localparam logic [1:0]  AXIS_Y     = 2'd1;
	localparam logic [1:0]  AXIS_Z     = 2'd2;
	localparam logic [1:0]  AXIS_NONE  = 2'd3;
	localparam int          SQRT_STEPS = 32;
	localparam logic [2:0]  JOB_LAST   = 3'd5;

	// what the output register gets loaded with
	typedef enum logic [1:0] {
		RES_QUERY = 2'd0,
		RES_HIT   = 2'd1,
		RES_MISS  = 2'd2
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic       start_load;
		logic       kind_load;
		logic       sq_load;
		logic       sum_load;
		logic       sqrt_step;
		logic       div_load;
		logic       div_step;
		logic       div_store;
		logic [1:0] job_axis;
		logic       job_next;
		logic       choose;
		logic       advance;
		logic       emit;
		res_t       res;
	} vrt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic start_zero;
		logic adv_end;
		logic out_free;
		logic out_valid;
	} vrt_sts_t;

endpackage

### rtl/core/voxel_ray_traversal_core.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_core
// Grid ray walker: normalizes a start direction, then steps voxel by voxel
// on each map answer until a solid voxel, the reach or the step limit.
//
//   channel  | signals                         | dir
//   ---------+---------------------------------+-----
//   input    | in_valid, in_stall, payload     | in
//   output   | out_valid, out_stall, payload   | out
//   config   | cfg_we, cfg_wdata               | in
//
// An answer goes through the choose, step and emit states to the output
// word; a solid answer goes straight to emit. A start runs the bit-serial
// root (32 steps) and the shared divider (FRAC_BITS+17 steps per division).
// in_stall is high while an item is in work; a stalled output word holds,
// and a new item is still taken while the last word waits.
// Reset clears the ray state (nc_q and cs_q to SATMAX) and sets reach to 10.0.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_core #(
	parameter int FRAC_BITS  = 16,
	parameter int STEP_LIMIT = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic [7:0]         voxel_kind,
	input  logic               voxel_solid,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic signed [15:0] vox_x,
	output logic signed [15:0] vox_y,
	output logic signed [15:0] vox_z,
	output logic signed [15:0] prev_x,
	output logic signed [15:0] prev_y,
	output logic signed [15:0] prev_z,
	output logic               hit,
	output logic [7:0]         hit_kind,
	output logic [1:0]         face_axis,
	output logic               face_negative,
	output logic [19:0]        hit_distance,
	input  logic               cfg_we,
	input  logic [19:0]        cfg_wdata
);
	import vrt_pkg::*;

	localparam int DIV_STEPS = FRAC_BITS + 17;

	vrt_cmd_t cmd;
	vrt_sts_t sts;

	// sequencer
	vrt_ctrl #(
		.DIV_STEPS(DIV_STEPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.voxel_solid(voxel_solid),
		.sts        (sts),
		.cmd        (cmd)
	);

	// arithmetic and state
	vrt_dp #(
		.FRAC_BITS (FRAC_BITS),
		.STEP_LIMIT(STEP_LIMIT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.origin_z     (origin_z),
		.dir_x        (dir_x),
		.dir_y        (dir_y),
		.dir_z        (dir_z),
		.voxel_kind   (voxel_kind),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.result_kind  (result_kind),
		.vox_x        (vox_x),
		.vox_y        (vox_y),
		.vox_z        (vox_z),
		.prev_x       (prev_x),
		.prev_y       (prev_y),
		.prev_z       (prev_z),
		.hit          (hit),
		.hit_kind     (hit_kind),
		.face_axis    (face_axis),
		.face_negative(face_negative),
		.hit_distance (hit_distance)
	);

endmodule

### rtl/core/vrt_dp.sv
// ----------------------------------------------------------------------------
// vrt_dp
// Datapath: ray state, bit-serial square root and divider for setup,
// axis choice and step, result word register.
// ----------------------------------------------------------------------------
module vrt_dp #(
	parameter int FRAC_BITS  = 16,
	parameter int STEP_LIMIT = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vrt_pkg::vrt_cmd_t  cmd,
	output vrt_pkg::vrt_sts_t  sts,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic [7:0]         voxel_kind,
	input  logic               cfg_we,
	input  logic [19:0]        cfg_wdata,
	input  logic               out_stall,
	output logic               out_valid,
	output logic               result_kind,
	output logic signed [15:0] vox_x,
	output logic signed [15:0] vox_y,
	output logic signed [15:0] vox_z,
	output logic signed [15:0] prev_x,
	output logic signed [15:0] prev_y,
	output logic signed [15:0] prev_z,
	output logic               hit,
	output logic [7:0]         hit_kind,
	output logic [1:0]         face_axis,
	output logic               face_negative,
	output logic [19:0]        hit_distance
);
	import vrt_pkg::*;

	localparam int NW = FRAC_BITS + 17;
	localparam int QW = (NW > 33) ? NW : 33;
	localparam int PW = FRAC_BITS + 33;
	localparam int FW = FRAC_BITS + 1;
	localparam int SW = $clog2(STEP_LIMIT + 1);
	localparam logic [31:0] REACH_CAP = 32'(10 * (64'd1 << FRAC_BITS));
	localparam logic [FW-1:0] ONE_FX = FW'(64'd1 << FRAC_BITS);

	logic [31:0]          reach_q;
	logic [31:0]          cur_q [3];
	logic [31:0]          last_q [3];
	logic [31:0]          nc_q [3];
	logic [31:0]          cs_q [3];
	logic [2:0]           nz_q;
	logic [2:0]           pos_q;
	logic [15:0]          mag_q [3];
	logic [FRAC_BITS-1:0] fr_q [3];
	logic [31:0]          sq_q [3];
	logic [31:0]          trav_q;
	logic [1:0]           last_axis_q;
	logic [1:0]           ax_q;
	logic [SW-1:0]        steps_q;
	logic [7:0]           kind_q;
	logic [63:0]          v_q;
	logic [31:0]          root_q;
	logic [34:0]          srem_q;
	logic [NW-1:0]        dq_q;
	logic [15:0]          drem_q;
	logic                 out_valid_q;

	logic signed [15:0] dir_in [3];
	logic signed [31:0] org_in [3];
	assign dir_in = '{dir_x, dir_y, dir_z};
	assign org_in = '{origin_x, origin_y, origin_z};

	logic [31:0] reach_lim;
	assign reach_lim = (reach_q < REACH_CAP) ? reach_q : REACH_CAP;

	// sqrt step
	logic [34:0] rem_sh, trial;
	assign rem_sh = {srem_q[32:0], v_q[63:62]};
	assign trial  = {1'b0, root_q, 2'b01};

	// divider step
	logic [15:0] dmag;
	logic [16:0] dsh;
	logic [17:0] ddiff;
	assign dmag  = mag_q[cmd.job_axis];
	assign dsh   = {drem_q, dq_q[NW-1]};
	assign ddiff = {1'b0, dsh} - {2'b00, dmag};

	// numerator of the current job
	logic [FW-1:0] fsel;
	logic [PW-1:0] prod;
	logic [QW-1:0] qext;
	logic [31:0]   qsat;
	assign fsel = pos_q[cmd.job_axis] ? (ONE_FX - FW'(fr_q[cmd.job_axis]))
	                                  : FW'(fr_q[cmd.job_axis]);
	assign prod = cmd.job_next ? PW'(fsel) * PW'(root_q)
	                           : PW'(root_q) << FRAC_BITS;
	assign qext = QW'(dq_q);
	assign qsat = ((dmag == 16'd0) || (|qext[QW-1:32])) ? SATMAX : qext[31:0];

	// step along the chosen axis
	logic [31:0]   nc_ax;
	logic [32:0]   nc_sum;
	logic [SW-1:0] steps_inc;
	assign nc_ax     = nc_q[ax_q];
	assign nc_sum    = {1'b0, nc_ax} + {1'b0, cs_q[ax_q]};
	assign steps_inc = steps_q + SW'(1);

	assign sts.start_zero = ((dir_x == 16'sd0) && (dir_y == 16'sd0) && (dir_z == 16'sd0))
	                        || (reach_q == 32'd0);
	assign sts.adv_end    = !nz_q[ax_q] || (nc_ax > reach_lim)
	                        || (steps_inc >= SW'(STEP_LIMIT));
	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.out_valid  = out_valid_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= REACH_CAP;
		end else if (cfg_we) begin
			reach_q <= 32'(cfg_wdata);
		end
	end

	// ray state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				cur_q[k]  <= '0;
				last_q[k] <= '0;
				nc_q[k]   <= SATMAX;
				cs_q[k]   <= SATMAX;
			end
			nz_q        <= '0;
			pos_q       <= '0;
			trav_q      <= '0;
			last_axis_q <= AXIS_NONE;
			steps_q     <= '0;
		end else begin
			if (cmd.start_load) begin
				for (int k = 0; k < 3; k++) begin
					cur_q[k]  <= 32'(org_in[k] >>> FRAC_BITS);
					last_q[k] <= 32'(org_in[k] >>> FRAC_BITS);
					nz_q[k]   <= (dir_in[k] != 16'sd0);
					pos_q[k]  <= (dir_in[k] > 16'sd0);
				end
				trav_q      <= '0;
				last_axis_q <= AXIS_NONE;
				steps_q     <= '0;
			end
			if (cmd.div_store) begin
				if (cmd.job_next) begin
					nc_q[cmd.job_axis] <= qsat;
				end else begin
					cs_q[cmd.job_axis] <= qsat;
				end
			end
			if (cmd.choose) begin
				for (int k = 0; k < 3; k++) begin
					last_q[k] <= cur_q[k];
				end
			end
			if (cmd.advance && nz_q[ax_q]) begin
				trav_q       <= nc_ax;
				cur_q[ax_q]  <= pos_q[ax_q] ? cur_q[ax_q] + 32'd1 : cur_q[ax_q] - 32'd1;
				nc_q[ax_q]   <= nc_sum[32] ? SATMAX : nc_sum[31:0];
				last_axis_q  <= ax_q;
				steps_q      <= steps_inc;
			end
		end
	end

	// setup arithmetic: magnitudes, squares, root, divider; voxel kind and axis choice
	always_ff @(posedge clk) begin
		if (cmd.start_load) begin
			for (int k = 0; k < 3; k++) begin
				mag_q[k] <= dir_in[k][15] ? 16'(~dir_in[k] + 16'sd1) : 16'(dir_in[k]);
				fr_q[k]  <= org_in[k][FRAC_BITS-1:0];
			end
		end
		if (cmd.sq_load) begin
			for (int k = 0; k < 3; k++) begin
				sq_q[k] <= 32'(mag_q[k]) * 32'(mag_q[k]);
			end
		end
		if (cmd.sum_load) begin
			v_q    <= {sq_q[0] + sq_q[1] + sq_q[2], 32'd0};
			root_q <= '0;
			srem_q <= '0;
		end
		if (cmd.sqrt_step) begin
			v_q <= {v_q[61:0], 2'b00};
			if (rem_sh >= trial) begin
				srem_q <= rem_sh - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				srem_q <= rem_sh;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.div_load) begin
			dq_q   <= NW'(prod >> 16);
			drem_q <= '0;
		end
		if (cmd.div_step) begin
			if (!ddiff[17]) begin
				drem_q <= ddiff[15:0];
				dq_q   <= {dq_q[NW-2:0], 1'b1};
			end else begin
				drem_q <= dsh[15:0];
				dq_q   <= {dq_q[NW-2:0], 1'b0};
			end
		end
		if (cmd.kind_load) begin
			kind_q <= voxel_kind;
		end
		if (cmd.choose) begin
			if (nc_q[0] <= nc_q[1] && nc_q[0] <= nc_q[2]) begin
				ax_q <= AXIS_X;
			end else if (nc_q[1] <= nc_q[0] && nc_q[1] <= nc_q[2]) begin
				ax_q <= AXIS_Y;
			end else begin
				ax_q <= AXIS_Z;
			end
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.res)
				RES_QUERY: begin
					result_kind   <= 1'b0;
					vox_x         <= cur_q[0][15:0];
					vox_y         <= cur_q[1][15:0];
					vox_z         <= cur_q[2][15:0];
					prev_x        <= '0;
					prev_y        <= '0;
					prev_z        <= '0;
					hit           <= 1'b0;
					hit_kind      <= '0;
					face_axis     <= AXIS_X;
					face_negative <= 1'b0;
					hit_distance  <= '0;
				end
				RES_HIT: begin
					result_kind   <= 1'b1;
					vox_x         <= cur_q[0][15:0];
					vox_y         <= cur_q[1][15:0];
					vox_z         <= cur_q[2][15:0];
					prev_x        <= last_q[0][15:0];
					prev_y        <= last_q[1][15:0];
					prev_z        <= last_q[2][15:0];
					hit           <= 1'b1;
					hit_kind      <= kind_q;
					face_axis     <= last_axis_q;
					face_negative <= (last_axis_q != AXIS_NONE) && pos_q[last_axis_q];
					hit_distance  <= trav_q[19:0];
				end
				// miss
				default: begin
					result_kind   <= 1'b1;
					vox_x         <= '0;
					vox_y         <= '0;
					vox_z         <= '0;
					prev_x        <= '0;
					prev_y        <= '0;
					prev_z        <= '0;
					hit           <= 1'b0;
					hit_kind      <= '0;
					face_axis     <= AXIS_NONE;
					face_negative <= 1'b0;
					hit_distance  <= '0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/vrt_ctrl.sv
// ----------------------------------------------------------------------------
// vrt_ctrl
// Controller: sequences ray setup (squares, root, six divisions), the
// per-answer choose and step, and the hand-off to the output register.
// ----------------------------------------------------------------------------
module vrt_ctrl #(
	parameter int DIV_STEPS = 33
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic              voxel_solid,
	input  vrt_pkg::vrt_sts_t sts,
	output vrt_pkg::vrt_cmd_t cmd
);
	import vrt_pkg::*;

	localparam int MAXS = (DIV_STEPS > SQRT_STEPS) ? DIV_STEPS : SQRT_STEPS;
	localparam int CW   = $clog2(MAXS);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_PREP   = 10'b00_0000_0010,
		ST_SUM    = 10'b00_0000_0100,
		ST_SQRT   = 10'b00_0000_1000,
		ST_DLOAD  = 10'b00_0001_0000,
		ST_DITER  = 10'b00_0010_0000,
		ST_DSTORE = 10'b00_0100_0000,
		ST_CHOOSE = 10'b00_1000_0000,
		ST_ADV    = 10'b01_0000_0000,
		ST_EMIT   = 10'b10_0000_0000
	} state_t;

	state_t        st_q, st_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [2:0]    job_q, job_d;
	res_t          res_q, res_d;
	logic          active_q, active_d;
	logic          in_acc;

	assign in_stall = (st_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// next state and commands
	always_comb begin
		st_d     = st_q;
		cnt_d    = cnt_q;
		job_d    = job_q;
		res_d    = res_q;
		active_d = active_q;
		cmd          = '0;
		cmd.res      = res_q;
		cmd.job_axis = job_q[2:1];
		cmd.job_next = job_q[0];
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (!action) begin
						cmd.start_load = 1'b1;
						if (sts.start_zero) begin
							res_d    = RES_MISS;
							active_d = 1'b0;
							st_d     = ST_EMIT;
						end else begin
							active_d = 1'b1;
							st_d     = ST_PREP;
						end
					end else if (active_q) begin
						cmd.kind_load = 1'b1;
						if (voxel_solid) begin
							res_d    = RES_HIT;
							active_d = 1'b0;
							st_d     = ST_EMIT;
						end else begin
							st_d = ST_CHOOSE;
						end
					end
				end
			end
			ST_PREP: begin
				cmd.sq_load = 1'b1;
				st_d        = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_load = 1'b1;
				cnt_d        = CW'(SQRT_STEPS - 1);
				st_d         = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q - CW'(1);
				if (cnt_q == '0) begin
					job_d = '0;
					st_d  = ST_DLOAD;
				end
			end
			ST_DLOAD: begin
				cmd.div_load = 1'b1;
				cnt_d        = CW'(DIV_STEPS - 1);
				st_d         = ST_DITER;
			end
			ST_DITER: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - CW'(1);
				if (cnt_q == '0) begin
					st_d = ST_DSTORE;
				end
			end
			ST_DSTORE: begin
				cmd.div_store = 1'b1;
				if (job_q == JOB_LAST) begin
					res_d = RES_QUERY;
					st_d  = ST_EMIT;
				end else begin
					job_d = job_q + 3'd1;
					st_d  = ST_DLOAD;
				end
			end
			ST_CHOOSE: begin
				cmd.choose = 1'b1;
				st_d       = ST_ADV;
			end
			ST_ADV: begin
				cmd.advance = 1'b1;
				if (sts.adv_end) begin
					res_d    = RES_MISS;
					active_d = 1'b0;
				end else begin
					res_d = RES_QUERY;
				end
				st_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cnt_q    <= '0;
			job_q    <= '0;
			res_q    <= RES_QUERY;
			active_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			cnt_q    <= cnt_d;
			job_q    <= job_d;
			res_q    <= res_d;
			active_q <= active_d;
		end
	end

`ifndef SYNTH
	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT && sts.out_free) |=> sts.out_valid)
		else $error("output word not loaded on emit");
	a_adv_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ADV) |=> (st_q == ST_EMIT))
		else $error("step did not produce a word");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DITER) |-> (cnt_q <= CW'(DIV_STEPS - 1)))
		else $error("divider count out of range");
	a_job_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DLOAD) |-> (job_q <= JOB_LAST))
		else $error("setup job out of range");
`endif

endmodule
